// ----- hw/rtl/shapr_pkg.sv -----
package shapr_pkg;

  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumRounds = 17;

  localparam logic [31:0] MaskReset = 32'h0000_8000;

  localparam logic [31:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ----- hw/rtl/sha256_paired_round_differential.sv -----
// Words with index 0 to 14 are stored as they are taken; the block is ready again at once.
// The word at index 15 starts a run: 17 rounds, each a sequence of steps on one shared
// four-operand 32-bit adder. Results then leave one per cycle while the output is not
// stalled. Input is stalled for the whole run and its emission.
// Reset (async, active low) clears the sequencer and the output valid and sets the mask
// to 0x8000; the message stores are not cleared.
module sha256_paired_round_differential (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] word_value_i,
  input  logic [3:0]  word_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] derived_word_o,
  output logic [3:0]  derived_index_o,
  output logic        is_last_o,
  output logic [31:0] e_difference_o,
  output logic        zero_hit_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhRun  = 2'd1;
  localparam logic [1:0] PhEmit = 2'd2;

  localparam logic [2:0] StSumB    = 3'd0;
  localparam logic [2:0] StSumD    = 3'd1;
  localparam logic [2:0] StWord    = 3'd2;
  localparam logic [2:0] StEBase   = 3'd3;
  localparam logic [2:0] StRndBase = 3'd4;
  localparam logic [2:0] StEDer    = 3'd5;
  localparam logic [2:0] StRndDer  = 3'd6;

  localparam logic [3:0] LastIdx = 4'd15;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  step_q, step_d;
  logic [4:0]  rnd_q, rnd_d;
  logic [3:0]  emit_q, emit_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] mask_q, mask_d;

  logic [31:0] base_q  [shapr_pkg::NumWords];
  logic [31:0] deriv_q [shapr_pkg::NumWords];
  logic [31:0] hb_q [8];
  logic [31:0] hd_q [8];
  logic [31:0] pb_q, pd_q, wd_q, en_q, diff_q;

  logic [31:0] out_word_q;
  logic [3:0]  out_index_q;
  logic        out_last_q;
  logic [31:0] out_ediff_q;
  logic        out_zero_q;

  logic        in_accept, start, emit_load, fin;
  logic [3:0]  rnd_idx;
  logic [31:0] bw_r, k_r, new_word;
  logic [31:0] add_a, add_b, add_c, add_d, add_sum;
  logic        add_cin;

  assign in_stall_o = (phase_q != PhIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign start      = in_accept && (word_index_i == LastIdx);
  assign emit_load  = (phase_q == PhEmit) && (!out_valid_q || !out_stall_i);
  assign fin        = rnd_q[4];
  assign rnd_idx    = rnd_q[3:0];
  assign bw_r       = base_q[rnd_idx];
  assign k_r        = shapr_pkg::RoundK[rnd_q];
  assign new_word   = (rnd_q == 5'd0) ? (base_q[0] ^ mask_q) : add_sum;

  always_comb begin
    add_a   = hb_q[3];
    add_b   = hb_q[7];
    add_c   = shapr_pkg::big_s1(hb_q[4]);
    add_d   = shapr_pkg::choose(hb_q[4], hb_q[5], hb_q[6]);
    add_cin = 1'b0;
    unique case (step_q)
      StSumB: begin
      end
      StSumD: begin
        add_a = hd_q[3];
        add_b = hd_q[7];
        add_c = shapr_pkg::big_s1(hd_q[4]);
        add_d = shapr_pkg::choose(hd_q[4], hd_q[5], hd_q[6]);
      end
      StWord: begin
        if (fin) begin
          add_a = shapr_pkg::small_s1(base_q[14]);
          add_b = base_q[9];
          add_c = shapr_pkg::small_s0(base_q[1]);
          add_d = base_q[0];
        end else begin
          add_a   = bw_r;
          add_b   = pb_q;
          add_c   = ~pd_q;
          add_d   = 32'd0;
          add_cin = 1'b1;
        end
      end
      StEBase: begin
        add_a = pb_q;
        add_b = k_r;
        add_c = fin ? wd_q : bw_r;
        add_d = 32'd0;
      end
      StRndBase: begin
        if (fin) begin
          add_a = shapr_pkg::small_s1(deriv_q[14]);
          add_b = deriv_q[9];
          add_c = shapr_pkg::small_s0(deriv_q[1]);
          add_d = deriv_q[0];
        end else begin
          add_a   = en_q;
          add_b   = ~hb_q[3];
          add_c   = shapr_pkg::big_s0(hb_q[0]);
          add_d   = shapr_pkg::major(hb_q[0], hb_q[1], hb_q[2]);
          add_cin = 1'b1;
        end
      end
      StEDer: begin
        add_a = pd_q;
        add_b = k_r;
        add_c = wd_q;
        add_d = 32'd0;
      end
      StRndDer: begin
        if (fin) begin
          add_a   = pd_q;
          add_b   = ~en_q;
          add_c   = 32'd0;
          add_d   = 32'd0;
          add_cin = 1'b1;
        end else begin
          add_a   = en_q;
          add_b   = ~hd_q[3];
          add_c   = shapr_pkg::big_s0(hd_q[0]);
          add_d   = shapr_pkg::major(hd_q[0], hd_q[1], hd_q[2]);
          add_cin = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign add_sum = add_a + add_b + add_c + add_d + {31'd0, add_cin};

  always_comb begin
    phase_d     = phase_q;
    step_d      = step_q;
    rnd_d       = rnd_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q;
    mask_d      = cfg_we_i ? cfg_wdata_i : mask_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (phase_q)
      PhIdle: begin
        if (start) begin
          phase_d = PhRun;
          step_d  = StSumB;
          rnd_d   = 5'd0;
        end
      end
      PhRun: begin
        if (step_q == StRndDer) begin
          step_d = StSumB;
          if (fin) begin
            phase_d = PhEmit;
            emit_d  = 4'd0;
          end else begin
            rnd_d = rnd_q + 5'd1;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      PhEmit: begin
        if (emit_load) begin
          out_valid_d = 1'b1;
          emit_d      = emit_q + 4'd1;
          if (emit_q == LastIdx) begin
            phase_d = PhIdle;
          end
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      step_q      <= StSumB;
      rnd_q       <= 5'd0;
      emit_q      <= 4'd0;
      out_valid_q <= 1'b0;
      mask_q      <= shapr_pkg::MaskReset;
    end else begin
      phase_q     <= phase_d;
      step_q      <= step_d;
      rnd_q       <= rnd_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
      mask_q      <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      base_q[word_index_i] <= word_value_i;
    end
    if (start) begin
      for (int i = 0; i < 8; i++) begin
        hb_q[i] <= shapr_pkg::InitHash[i];
        hd_q[i] <= shapr_pkg::InitHash[i];
      end
    end
    if (phase_q == PhRun) begin
      unique case (step_q)
        StSumB: pb_q <= add_sum;
        StSumD: pd_q <= add_sum;
        StWord: begin
          if (fin) begin
            wd_q <= add_sum;
          end else begin
            wd_q             <= new_word;
            deriv_q[rnd_idx] <= new_word;
          end
        end
        StEBase: en_q <= add_sum;
        StRndBase: begin
          if (fin) begin
            wd_q <= add_sum;
          end else begin
            hb_q[0] <= add_sum;
            hb_q[1] <= hb_q[0];
            hb_q[2] <= hb_q[1];
            hb_q[3] <= hb_q[2];
            hb_q[4] <= en_q;
            hb_q[5] <= hb_q[4];
            hb_q[6] <= hb_q[5];
            hb_q[7] <= hb_q[6];
          end
        end
        StEDer: begin
          if (fin) begin
            pd_q <= add_sum;
          end else begin
            en_q <= add_sum;
          end
        end
        StRndDer: begin
          if (fin) begin
            diff_q <= add_sum;
          end else begin
            hd_q[0] <= add_sum;
            hd_q[1] <= hd_q[0];
            hd_q[2] <= hd_q[1];
            hd_q[3] <= hd_q[2];
            hd_q[4] <= en_q;
            hd_q[5] <= hd_q[4];
            hd_q[6] <= hd_q[5];
            hd_q[7] <= hd_q[6];
          end
        end
        default: begin
        end
      endcase
    end
    if (emit_load) begin
      out_word_q  <= deriv_q[emit_q];
      out_index_q <= emit_q;
      out_last_q  <= (emit_q == LastIdx);
      out_ediff_q <= (emit_q == LastIdx) ? diff_q : 32'd0;
      out_zero_q  <= (emit_q == LastIdx) && (diff_q == 32'd0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign derived_word_o  = out_word_q;
  assign derived_index_o = out_index_q;
  assign is_last_o       = out_last_q;
  assign e_difference_o  = out_ediff_q;
  assign zero_hit_o      = out_zero_q;

endmodule

// ----- hw/rtl/shapr_checker.sv -----
module shapr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [31:0] cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] word_value_i,
  input logic [3:0]  word_index_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] derived_word_o,
  input logic [3:0]  derived_index_o,
  input logic        is_last_o,
  input logic [31:0] e_difference_o,
  input logic        zero_hit_o
);

  logic cfg_seen;
  assign cfg_seen = cfg_we_i && (cfg_wdata_i == cfg_wdata_i);

  a_start_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && word_index_i == 4'd15 && word_value_i == word_value_i)
      |=> in_stall_o)
    else $error("run start did not stall input");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_last_o == (derived_index_o == 4'd15)))
    else $error("last flag does not match index");

  a_zero_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !cfg_seen) || (out_valid_o && cfg_seen)
      |-> (zero_hit_o == (is_last_o && e_difference_o == 32'd0)))
    else $error("zero flag inconsistent with difference");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && is_last_o) |=> !out_valid_o)
    else $error("word emitted right after last");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(derived_word_o)))
    else $error("stalled output word changed");

endmodule

bind sha256_paired_round_differential shapr_checker u_shapr_checker (.*);

// ----- dv/tb_sha256_paired_round_differential.sv -----
`timescale 1ns / 100ps

module tb_sha256_paired_round_differential;

  localparam logic [3:0] StartIndex   = 4'd15;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned RandomWords  = 130;

  typedef logic [7:0][31:0] hash_regs_t;

  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  idx;
    logic        last;
    logic [31:0] ediff;
    logic        hit;
  } derived_res_t;

  localparam hash_regs_t ShaIv = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ShaK [17] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] word_value_i;
  logic [3:0]  word_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] derived_word_o;
  logic [3:0]  derived_index_o;
  logic        is_last_o;
  logic [31:0] e_difference_o;
  logic        zero_hit_o;

  logic [31:0]  base_msg [16];
  logic [31:0]  xor_mask;
  derived_res_t derived_due [$];
  int           mismatch_count;
  int           words_sent;
  int           cycle_count;
  bit           in_burst;
  derived_res_t want_res;
  derived_res_t got_res;

  sha256_paired_round_differential uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .word_value_i    (word_value_i),
    .word_index_i    (word_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .derived_word_o  (derived_word_o),
    .derived_index_o (derived_index_o),
    .is_last_o       (is_last_o),
    .e_difference_o  (e_difference_o),
    .zero_hit_o      (zero_hit_o)
  );

  function automatic logic [31:0] rotr32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(logic [31:0] x);
    return rotr32(x, 2) ^ rotr32(x, 13) ^ rotr32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(logic [31:0] x);
    return rotr32(x, 6) ^ rotr32(x, 11) ^ rotr32(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(logic [31:0] x);
    return rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(logic [31:0] x);
    return rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch32(logic [31:0] e, logic [31:0] f, logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj32(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic logic [31:0] round_t1(hash_regs_t s, int r, logic [31:0] w);
    return s[7] + bsig1(s[4]) + ch32(s[4], s[5], s[6]) + ShaK[r] + w;
  endfunction

  function automatic hash_regs_t sha_round(hash_regs_t s, int r, logic [31:0] w);
    logic [31:0] t1;
    logic [31:0] t2;
    hash_regs_t  nxt;
    t1 = round_t1(s, r, w);
    t2 = bsig0(s[0]) + maj32(s[0], s[1], s[2]);
    nxt[7] = s[6];
    nxt[6] = s[5];
    nxt[5] = s[4];
    nxt[4] = s[3] + t1;
    nxt[3] = s[2];
    nxt[2] = s[1];
    nxt[1] = s[0];
    nxt[0] = t1 + t2;
    return nxt;
  endfunction

  // build the second message round by round, cancel the e difference, then round 16
  function automatic void derive_second_message();
    hash_regs_t   sb;
    hash_regs_t   sd;
    logic [31:0]  dmsg [16];
    logic [31:0]  fix;
    logic [31:0]  w16b;
    logic [31:0]  w16d;
    logic [31:0]  ediff;
    derived_res_t res;
    int           r;
    sb = ShaIv;
    sd = ShaIv;
    dmsg[0] = base_msg[0] ^ xor_mask;
    sb = sha_round(sb, 0, base_msg[0]);
    sd = sha_round(sd, 0, dmsg[0]);
    for (r = 1; r < 16; r++) begin
      fix = (sd[3] - sb[3]) + (sd[7] - sb[7]) + (bsig1(sd[4]) - bsig1(sb[4]))
          + (ch32(sd[4], sd[5], sd[6]) - ch32(sb[4], sb[5], sb[6]));
      dmsg[r] = base_msg[r] - fix;
      sb = sha_round(sb, r, base_msg[r]);
      sd = sha_round(sd, r, dmsg[r]);
    end
    w16b = ssig1(base_msg[14]) + base_msg[9] + ssig0(base_msg[1]) + base_msg[0];
    w16d = ssig1(dmsg[14]) + dmsg[9] + ssig0(dmsg[1]) + dmsg[0];
    ediff = (sd[3] + round_t1(sd, 16, w16d)) - (sb[3] + round_t1(sb, 16, w16b));
    for (r = 0; r < 16; r++) begin
      res.word  = dmsg[r];
      res.idx   = 4'(r);
      res.last  = (r == 15);
      res.ediff = (r == 15) ? ediff : 32'h0;
      res.hit   = (r == 15) && (ediff == 32'h0);
      derived_due.push_back(res);
    end
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 92) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int send_gap();
    if (in_burst) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return gap_len();
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(logic [31:0] value, logic [3:0] index);
    int gap;
    in_valid_i   <= 1'b1;
    word_value_i <= value;
    word_index_i <= index;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    base_msg[index] = value;
    if (index == StartIndex) derive_second_message();
    gap = send_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (derived_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mask(logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    xor_mask = value;
  endtask

  task automatic test_reset_mask_run();
    int i;
    in_burst = 1'b0;
    send_word(32'h0000_0000, 4'd0);
    send_word(32'hffff_ffff, 4'd1);
    send_word(32'h5555_5555, 4'd2);
    send_word(32'haaaa_aaaa, 4'd3);
    for (i = 4; i < 15; i++) send_word(pick_word(), 4'(i));
    send_word(32'h8000_0000, StartIndex);
    wait_idle();
  endtask

  task automatic test_mask_extremes();
    write_mask(32'h0000_0000);
    send_word(32'hffff_ffff, StartIndex);
    wait_idle();
    write_mask(32'hffff_ffff);
    send_word(32'h0000_0000, StartIndex);
    wait_idle();
    write_mask(32'h0000_0001);
    send_word(32'hffff_ffff, 4'd0);
    send_word(32'h0000_0000, 4'd14);
    send_word($urandom, StartIndex);
    send_word($urandom, StartIndex);
    wait_idle();
  endtask

  task automatic test_random_messages();
    int order [15];
    int i;
    int j;
    int t;
    int n;
    while (words_sent < RandomWords) begin
      wait_idle();
      if ($urandom_range(0, 2) == 0) write_mask(pick_mask());
      in_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        for (i = 0; i < 15; i++) order[i] = i;
        for (i = 14; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        for (i = 0; i < 15; i++) send_word(pick_word(), 4'(order[i]));
        send_word(pick_word(), StartIndex);
      end else begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) send_word(pick_word(), 4'($urandom_range(0, 14)));
        if ($urandom_range(0, 1) == 0) send_word(pick_word(), StartIndex);
      end
    end
    in_burst = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : out_stall_gen
    int hold_cycles;
    int calm_cycles;
    hold_cycles = 0;
    calm_cycles = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (calm_cycles > 0) begin
          calm_cycles--;
        end else if ($urandom_range(0, 15) == 0) begin
          calm_cycles = $urandom_range(20, 200);
        end else if ($urandom_range(0, 2) == 0) begin
          hold_cycles = gap_len();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_res = {derived_word_o, derived_index_o, is_last_o, e_difference_o, zero_hit_o};
      if (derived_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: idx %0d word %h last %b ediff %h hit %b",
                   got_res.idx, got_res.word, got_res.last, got_res.ediff, got_res.hit);
      end else begin
        want_res = derived_due.pop_front();
        if (got_res !== want_res) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: want idx %0d word %h last %b ediff %h hit %b",
                     want_res.idx, want_res.word, want_res.last, want_res.ediff,
                     want_res.hit, "\n          got  idx %0d word %h last %b ediff %h hit %b",
                     got_res.idx, got_res.word, got_res.last, got_res.ediff, got_res.hit);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 32'h0;
    in_valid_i     = 1'b0;
    word_value_i   = 32'h0;
    word_index_i   = 4'h0;
    xor_mask       = 32'h0000_8000;
    mismatch_count = 0;
    words_sent     = 0;
    cycle_count    = 0;
    in_burst       = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_mask_run();
    test_mask_extremes();
    test_random_messages();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
